@@ rtl/pr_pkg.sv @@
// shared constants, types and helpers of the packet reassembler
package pr_pkg;

  localparam int SLOTS       = 4;
  localparam int MAX_PACKETS = 16;
  localparam int CHANNELS    = 16;
  localparam int CHUNK_BYTES = 15;

  localparam logic [7:0] FRAME_MARK = 8'hAA;

  localparam int DEPTH  = SLOTS * MAX_PACKETS;
  localparam int DATA_W = 8 * CHUNK_BYTES;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PKT_W  = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam int CNT_W  = $clog2(MAX_PACKETS + 1);
  localparam int LEN_W  = $clog2(CHUNK_BYTES * MAX_PACKETS + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // result status codes
  localparam logic [1:0] STATUS_IGNORED  = 2'd0;
  localparam logic [1:0] STATUS_STORED   = 2'd1;
  localparam logic [1:0] STATUS_CHUNK    = 2'd2;
  localparam logic [1:0] STATUS_REJECTED = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic load_frame;
    logic commit;
    logic rd_issue;
    logic chunk_load;
  } pr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic complete;
    logic out_free;
    logic last_chunk;
  } pr_stat_t;

  // payload memory address of one packet of one slot
  function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [PKT_W-1:0] p);
    return ADDR_W'(32'(s) * MAX_PACKETS + 32'(p));
  endfunction

endpackage

@@ rtl/pr_if.sv @@
// valid/ready channels for frames and results
interface pr_frame_if;
  logic        valid;
  logic        ready;
  logic [3:0]  channel;
  logic        length_ok;
  logic [7:0]  marker;
  logic [7:0]  total_packets;
  logic [7:0]  packet_number;
  logic [15:0] message_length;
  logic [63:0] payload_low;
  logic [55:0] payload_high;

  modport source (output valid, channel, length_ok, marker, total_packets, packet_number,
                  message_length, payload_low, payload_high, input ready);
  modport sink (input valid, channel, length_ok, marker, total_packets, packet_number,
                message_length, payload_low, payload_high, output ready);
endinterface

interface pr_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  out_channel;
  logic [4:0]  chunk_number;
  logic [3:0]  byte_count;
  logic [63:0] data_low;
  logic [55:0] data_high;
  logic        last;

  modport source (output valid, status, out_channel, chunk_number, byte_count, data_low,
                  data_high, last, input ready);
  modport sink (input valid, status, out_channel, chunk_number, byte_count, data_low,
                data_high, last, output ready);
endinterface

@@ rtl/packet_reassembler.sv @@
// top level of the packet reassembler
// Rebuilds messages from 20-byte frames. Each accepted frame word gives one result word
// (ignored, stored, or rejected), except a frame that completes its message, which gives one
// chunk word per packet in packet order, the last one flagged. A frame is accepted, then
// evaluated against the slot table; for a completing frame each chunk is then a read of
// the payload memory with registered output followed by a load of the result register.
// Stalls on the result side hold the evaluation and each load of the result register.
// A new frame word is taken while the last result word still waits to be taken. There is
// no clearing pass: payload memory entries are only read after they were written.
module packet_reassembler import pr_pkg::*; (
  input logic          clk,
  input logic          rst,
  pr_frame_if.sink     frame,
  pr_result_if.source  result
);

  pr_cmd_t  cmd;
  pr_stat_t stat;

  // controller
  pr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (frame.valid),
    .in_ready (frame.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  pr_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .channel        (frame.channel),
    .length_ok      (frame.length_ok),
    .marker         (frame.marker),
    .total_packets  (frame.total_packets),
    .packet_number  (frame.packet_number),
    .message_length (frame.message_length),
    .payload_low    (frame.payload_low),
    .payload_high   (frame.payload_high),
    .result         (result)
  );

endmodule

@@ rtl/pr_ram.sv @@
// generic single write port ram with registered read
module pr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/pr_ctrl.sv @@
// controller state machine of the packet reassembler
module pr_ctrl import pr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  pr_stat_t stat,
  output pr_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_LOAD = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_frame = 1'b1;
          state_next     = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = stat.complete ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat.out_free) begin
          cmd.chunk_load = 1'b1;
          state_next     = stat.last_chunk ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/pr_datapath.sv @@
// frame register, slot table, payload memory and result register
module pr_datapath import pr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  pr_cmd_t     cmd,
  output pr_stat_t    stat,
  input  logic [3:0]  channel,
  input  logic        length_ok,
  input  logic [7:0]  marker,
  input  logic [7:0]  total_packets,
  input  logic [7:0]  packet_number,
  input  logic [15:0] message_length,
  input  logic [63:0] payload_low,
  input  logic [55:0] payload_high,
  pr_result_if.source result
);

  // latched frame
  logic [3:0]  f_channel;
  logic        f_ok;
  logic [7:0]  f_marker;
  logic [7:0]  f_total;
  logic [7:0]  f_num;
  logic [15:0] f_len;
  logic [63:0] f_lo;
  logic [55:0] f_hi;

  // slot table
  logic [SLOTS-1:0]       slot_valid;
  logic [3:0]             slot_channel [SLOTS];
  logic [CNT_W-1:0]       slot_total [SLOTS];
  logic [LEN_W-1:0]       slot_length [SLOTS];
  logic [MAX_PACKETS-1:0] slot_map [SLOTS];
  logic [CNT_W-1:0]       slot_count [SLOTS];

  // chunk walk
  logic [SLOT_W-1:0] em_slot;
  logic [CNT_W-1:0]  em_total;
  logic [PKT_W-1:0]  em_idx;
  logic [LEN_W-1:0]  em_rem;
  logic [3:0]        em_channel;

  // evaluation signals
  logic                   malformed;
  logic                   bad;
  logic                   hit;
  logic [SLOT_W-1:0]      hit_idx;
  logic                   free_any;
  logic [SLOT_W-1:0]      free_idx;
  logic [SLOT_W-1:0]      tgt;
  logic [PKT_W-1:0]       num_idx;
  logic [MAX_PACKETS-1:0] tgt_map;
  logic [CNT_W-1:0]       tgt_cnt;
  logic [CNT_W-1:0]       new_cnt;
  logic                   store;
  logic                   complete;
  logic [1:0]             single_status;
  logic [3:0]             chunk_cnt;
  logic [CNT_W-1:0]       chunk_pos;
  logic [DATA_W-1:0]      rdata;
  logic                   out_free;

  // frame checks
  assign malformed = !f_ok || (f_marker != FRAME_MARK) || (32'(f_channel) >= CHANNELS);
  assign bad = (f_num == 8'd0) || (f_num > f_total) || (32'(f_total) > MAX_PACKETS) ||
               (32'(f_len) > CHUNK_BYTES * 32'(f_total));

  // slot search: first matching slot, else first free slot
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_valid[s]) begin
        if (!hit && slot_channel[s] == f_channel && slot_total[s] == CNT_W'(f_total) &&
            slot_length[s] == LEN_W'(f_len)) begin
          hit     = 1'b1;
          hit_idx = SLOT_W'(s);
        end
      end else if (!free_any) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(s);
      end
    end
  end

  // target slot and new packet count
  assign tgt      = hit ? hit_idx : free_idx;
  assign num_idx  = PKT_W'(f_num - 8'd1);
  assign tgt_map  = hit ? slot_map[tgt] : '0;
  assign tgt_cnt  = hit ? slot_count[tgt] : '0;
  assign new_cnt  = tgt_map[num_idx] ? tgt_cnt : tgt_cnt + CNT_W'(1);
  assign store    = !malformed && !bad && (hit || free_any);
  assign complete = store && (new_cnt == CNT_W'(f_total));

  // status of a frame that gives a single result
  always_comb begin
    priority if (malformed) begin
      single_status = STATUS_IGNORED;
    end else if (!store) begin
      single_status = STATUS_REJECTED;
    end else begin
      single_status = STATUS_STORED;
    end
  end

  // byte count and position of the chunk being emitted
  assign chunk_cnt = (em_rem > LEN_W'(CHUNK_BYTES)) ? 4'(CHUNK_BYTES) : 4'(em_rem);
  assign chunk_pos = CNT_W'(em_idx) + CNT_W'(1);
  assign out_free  = !result.valid || result.ready;

  assign stat.complete   = complete;
  assign stat.out_free   = out_free;
  assign stat.last_chunk = (chunk_pos == em_total);

  // payload store
  pr_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (cmd.commit && store),
    .waddr (store_addr(tgt, num_idx)),
    .wdata ({f_hi, f_lo}),
    .re    (cmd.rd_issue),
    .raddr (store_addr(em_slot, em_idx)),
    .rdata (rdata)
  );

  // frame register
  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      f_channel <= channel;
      f_ok      <= length_ok;
      f_marker  <= marker;
      f_total   <= total_packets;
      f_num     <= packet_number;
      f_len     <= message_length;
      f_lo      <= payload_low;
      f_hi      <= payload_high;
    end
  end

  // slot table update
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        slot_channel[s] <= '0;
        slot_total[s]   <= '0;
        slot_length[s]  <= '0;
        slot_map[s]     <= '0;
        slot_count[s]   <= '0;
      end
    end else if (cmd.commit && store) begin
      if (complete) begin
        slot_valid[tgt] <= 1'b0;
        slot_map[tgt]   <= '0;
        slot_count[tgt] <= '0;
      end else begin
        slot_valid[tgt]        <= 1'b1;
        slot_channel[tgt]      <= f_channel;
        slot_total[tgt]        <= CNT_W'(f_total);
        slot_length[tgt]       <= LEN_W'(f_len);
        slot_map[tgt]          <= tgt_map | (MAX_PACKETS'(1) << num_idx);
        slot_count[tgt]        <= new_cnt;
      end
    end
  end

  // chunk walk registers
  always_ff @(posedge clk) begin
    if (cmd.commit && complete) begin
      em_slot    <= tgt;
      em_total   <= CNT_W'(f_total);
      em_idx     <= '0;
      em_rem     <= LEN_W'(f_len);
      em_channel <= f_channel;
    end else if (cmd.chunk_load) begin
      em_idx <= em_idx + PKT_W'(1);
      em_rem <= em_rem - LEN_W'(chunk_cnt);
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if ((cmd.commit && !complete) || cmd.chunk_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.commit && !complete) begin
      result.status       <= single_status;
      result.out_channel  <= f_channel;
      result.chunk_number <= '0;
      result.byte_count   <= '0;
      result.data_low     <= '0;
      result.data_high    <= '0;
      result.last         <= 1'b1;
    end else if (cmd.chunk_load) begin
      result.status       <= STATUS_CHUNK;
      result.out_channel  <= em_channel;
      result.chunk_number <= 5'(chunk_pos);
      result.byte_count   <= chunk_cnt;
      result.data_low     <= rdata[63:0];
      result.data_high    <= rdata[DATA_W-1:64];
      result.last         <= (chunk_pos == em_total);
    end
  end

endmodule

@@ rtl/pr_checker.sv @@
// port-level checks of the packet reassembler and their binding
module pr_checker import pr_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [4:0] out_chunk,
  input logic [3:0] out_count,
  input logic       out_last
);

  // a stalled result word holds its valid, status, chunk number and last flag
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_chunk) &&
    $stable(out_last))
    else $error("result word changed while stalled");

  // single results are final and carry no chunk
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != STATUS_CHUNK |->
    out_last && out_chunk == 5'd0 && out_count == 4'd0)
    else $error("non-chunk result with chunk fields");

  // chunks are numbered from one
  a_chunk_num: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == STATUS_CHUNK |-> out_chunk != 5'd0)
    else $error("chunk with number zero");

  // no new frame while a message is still being walked out
  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == STATUS_CHUNK && !out_last |-> !in_ready)
    else $error("frame taken during chunk walk");

endmodule

bind packet_reassembler pr_checker u_pr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (frame.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_status (result.status),
  .out_chunk  (result.chunk_number),
  .out_count  (result.byte_count),
  .out_last   (result.last)
);
